### sv/path_bounce_depth_gate_macros.svh
// Assertion helpers for the gate's top-level RTL.
`ifndef PATH_BOUNCE_DEPTH_GATE_MACROS_SVH
`define PATH_BOUNCE_DEPTH_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBDG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PBDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pbdg_pkg.sv
`timescale 1ns / 1ps

package pbdg_pkg;

  localparam int unsigned EV_W       = 8;
  localparam int unsigned BLOCKED_W  = 6;
  localparam int unsigned NUM_CAT    = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  // Event mask bit positions
  localparam int unsigned EV_DIFFUSE  = 0;
  localparam int unsigned EV_GLOSSY   = 1;
  localparam int unsigned EV_SPECULAR = 2;
  localparam int unsigned EV_REFLECT  = 3;
  localparam int unsigned EV_TRANSMIT = 4;
  localparam int unsigned EV_VOLUME   = 5;

  // Counter categories
  localparam int unsigned CAT_DIFFUSE  = 0;
  localparam int unsigned CAT_GLOSSY   = 1;
  localparam int unsigned CAT_SPECULAR = 2;
  localparam int unsigned CAT_TRANSMIT = 3;
  localparam int unsigned CAT_VOLUME   = 4;

  // event mask bit that belongs to each category
  localparam int unsigned CAT_EV_BIT [NUM_CAT] = '{
    EV_DIFFUSE, EV_GLOSSY, EV_SPECULAR, EV_TRANSMIT, EV_VOLUME
  };

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOSSY_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSMIT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_LIMIT   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_EVENT = 2'd1,
    ST_BAD_COUNT = 2'd2
  } status_t;

  typedef struct packed {
    logic [BLOCKED_W-1:0] blocked;
    status_t              status;
  } verdict_t;

endpackage

### sv/path_bounce_depth_gate.sv
`timescale 1ns / 1ps
// An accepted transaction moves from the input register to the result register on out_*.
// Throughput: one transaction per cycle unless out_tready stalls; the input register and
//   the result register each advance when the stage after them is empty or being drained.
// Reset (rst_n, synchronous, active low): both pipeline stages empty, all limits zero.
// The check itself is a single pass of compares and increments between the two registers.

`include "path_bounce_depth_gate_macros.svh"

module path_bounce_depth_gate #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pbdg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COUNT_WIDTH-1:0]              cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // event_mask, diffuse_count, glossy_count, specular_count,
  // transmission_count, volume_count; zero padded to whole bytes
  input  logic [((pbdg_pkg::EV_W + pbdg_pkg::NUM_CAT * COUNT_WIDTH + 7) / 8) * 8 - 1:0]
                                              in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, blocked_mask, new_diffuse, new_glossy, new_specular,
  // new_transmission, new_volume; zero padded to whole bytes
  output logic [((2 + pbdg_pkg::BLOCKED_W + pbdg_pkg::NUM_CAT * COUNT_WIDTH + 7) / 8) * 8 - 1:0]
                                              out_tdata
);

  localparam int unsigned IN_BITS  = pbdg_pkg::EV_W + pbdg_pkg::NUM_CAT * COUNT_WIDTH;
  localparam int unsigned OUT_BITS = 2 + pbdg_pkg::BLOCKED_W + pbdg_pkg::NUM_CAT * COUNT_WIDTH;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // Limit registers
  // ---------------------------------------------------------------------------
  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] limits;

  pbdg_cfg_regs #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  // ---------------------------------------------------------------------------
  // Pipeline handshake: stage 1 holds the input transaction, stage 2 the result.
  // Ready ripples back so both stages can be full while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [IN_BITS-1:0]  s1_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [OUT_BITS-1:0] out_payload_r;
  logic [OUT_BITS-1:0] out_payload_nxt;
  logic                s2_free;
  logic                s2_load;
  logic                in_fire;

  assign s2_free   = !out_valid_r || out_tready;
  assign s2_load   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata[IN_BITS-1:0];
    end
    if (s2_load) begin
      out_payload_r <= out_payload_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Event and counter check
  // ---------------------------------------------------------------------------
  logic [pbdg_pkg::EV_W-1:0]                     s1_event;
  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] s1_counts;
  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] new_counts;
  pbdg_pkg::verdict_t                            verdict;

  assign s1_event  = s1_data_r[pbdg_pkg::EV_W-1:0];
  assign s1_counts = s1_data_r[IN_BITS-1:pbdg_pkg::EV_W];

  pbdg_eval #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_eval (
    .event_mask (s1_event),
    .counts     (s1_counts),
    .limits     (limits),
    .verdict    (verdict),
    .new_counts (new_counts)
  );

  // status sits in the lowest bits, then blocked_mask, then the counters
  assign out_payload_nxt = {new_counts, verdict};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_payload_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PBDG_ASSERT_NEXT(a_in_fire_fills_s1, clk, rst_n, in_fire, s1_valid_r,
    "accepted transaction did not land in the input stage")
  `PBDG_ASSERT_IMPL(a_no_overrun, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready,
    "input accepted while both stages are full and stalled")
  `PBDG_ASSERT_IMPL(a_error_not_blocked, clk, rst_n,
    out_valid_r && (out_payload_r[1:0] != pbdg_pkg::ST_OK),
    out_payload_r[2 + pbdg_pkg::BLOCKED_W - 1:2] == '0,
    "blocked mask set on an error result")

endmodule

### sv/pbdg_cfg_regs.sv
`timescale 1ns / 1ps

module pbdg_cfg_regs #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_we,
  input  logic [pbdg_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [COUNT_WIDTH-1:0]                        cfg_data,
  output logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] limits
);

  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] limit_r;
  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] limit_nxt;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pbdg_pkg::REG_DIFFUSE_LIMIT:  limit_nxt[pbdg_pkg::CAT_DIFFUSE]  = cfg_data;
        pbdg_pkg::REG_GLOSSY_LIMIT:   limit_nxt[pbdg_pkg::CAT_GLOSSY]   = cfg_data;
        pbdg_pkg::REG_SPECULAR_LIMIT: limit_nxt[pbdg_pkg::CAT_SPECULAR] = cfg_data;
        pbdg_pkg::REG_TRANSMIT_LIMIT: limit_nxt[pbdg_pkg::CAT_TRANSMIT] = cfg_data;
        pbdg_pkg::REG_VOLUME_LIMIT:   limit_nxt[pbdg_pkg::CAT_VOLUME]   = cfg_data;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign limits = limit_r;

endmodule

### sv/pbdg_eval.sv
`timescale 1ns / 1ps

module pbdg_eval #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [pbdg_pkg::EV_W-1:0]                     event_mask,
  input  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] counts,
  input  logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] limits,
  output pbdg_pkg::verdict_t                            verdict,
  output logic [pbdg_pkg::NUM_CAT-1:0][COUNT_WIDTH-1:0] new_counts
);

  localparam int unsigned SUM_W = COUNT_WIDTH + 2;

  logic                               ev_known;
  logic                               ev_ok;
  logic [SUM_W-1:0]                   surf_sum;
  logic                               bad;
  logic [pbdg_pkg::BLOCKED_W-1:0]     blocked;
  logic [pbdg_pkg::NUM_CAT-1:0]       hit;

  always_comb begin
    ev_known = (event_mask != '0) &&
               (event_mask[pbdg_pkg::EV_W-1:pbdg_pkg::BLOCKED_W] == '0);
    // volume must stand alone; surface needs one family and one direction
    if (event_mask[pbdg_pkg::EV_VOLUME]) begin
      ev_ok = ev_known &&
              (event_mask[pbdg_pkg::BLOCKED_W-1:0] ==
               pbdg_pkg::BLOCKED_W'(1 << pbdg_pkg::EV_VOLUME));
    end else begin
      ev_ok = ev_known &&
              $onehot(event_mask[pbdg_pkg::EV_SPECULAR:pbdg_pkg::EV_DIFFUSE]) &&
              $onehot(event_mask[pbdg_pkg::EV_TRANSMIT:pbdg_pkg::EV_REFLECT]);
    end

    surf_sum = SUM_W'(counts[pbdg_pkg::CAT_DIFFUSE]) +
               SUM_W'(counts[pbdg_pkg::CAT_GLOSSY]) +
               SUM_W'(counts[pbdg_pkg::CAT_SPECULAR]);
    bad = SUM_W'(counts[pbdg_pkg::CAT_TRANSMIT]) > surf_sum;

    blocked = '0;
    for (int i = 0; i < pbdg_pkg::NUM_CAT; i++) begin
      hit[i] = event_mask[pbdg_pkg::CAT_EV_BIT[i]];
      if (counts[i] > limits[i]) begin
        bad = 1'b1;
      end
      if (hit[i] && (counts[i] >= limits[i])) begin
        blocked[pbdg_pkg::CAT_EV_BIT[i]] = 1'b1;
      end
    end

    new_counts      = counts;
    verdict.status  = pbdg_pkg::ST_OK;
    verdict.blocked = '0;
    priority if (!ev_ok) begin
      verdict.status = pbdg_pkg::ST_BAD_EVENT;
    end else if (bad) begin
      verdict.status = pbdg_pkg::ST_BAD_COUNT;
    end else if (blocked != '0) begin
      verdict.blocked = blocked;
    end else begin
      // below limit, so no wrap
      for (int i = 0; i < pbdg_pkg::NUM_CAT; i++) begin
        if (hit[i]) begin
          new_counts[i] = counts[i] + COUNT_WIDTH'(1);
        end
      end
    end
  end

endmodule
